@@ hw/rtl/mzf_pkg.sv @@
package mzf_pkg;

  // Default sizes, handed to the top level parameters
  localparam int unsigned RegWordsDef   = 4096;
  localparam int unsigned ChunkBytesDef = 4096;

  // Field widths
  localparam int unsigned ActionW = 2;
  localparam int unsigned IndexW  = 12;
  localparam int unsigned DataW   = 64;
  localparam int unsigned LenW    = 13;

  // Width used to compare an index against the register-file depth
  localparam int unsigned IdxCmpW = 17;

  // Action codes
  localparam logic [ActionW-1:0] ActRead  = 2'd0;
  localparam logic [ActionW-1:0] ActWrite = 2'd1;
  localparam logic [ActionW-1:0] ActTick  = 2'd2;
  localparam logic [ActionW-1:0] ActNone  = 2'd3;

  // Register word indexes
  localparam logic [IndexW-1:0] WordFirst     = 12'h606;
  localparam logic [IndexW-1:0] WordLast      = 12'h607;
  localparam logic [IndexW-1:0] WordOperation = 12'h700;

  // Operation code that starts a zero fill
  localparam logic [DataW-1:0] OpcodeZeroFill = 64'h11;

  // Queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = 1;
  localparam int unsigned QCntW      = 2;

  // One classified request on its way from the front to the back
  typedef struct packed {
    logic              mem_we;
    logic              mem_re;
    logic [IndexW-1:0] index;
    logic [DataW-1:0]  wdata;
    logic              fill_valid;
    logic [DataW-1:0]  fill_address;
    logic [LenW-1:0]   fill_length;
    logic              fill_last;
    logic              op_error;
    logic              busy;
  } mzf_entry_t;

endpackage

@@ hw/rtl/mzf_front.sv @@
module mzf_front import mzf_pkg::*; #(
  parameter int unsigned RegWords   = RegWordsDef,
  parameter int unsigned ChunkBytes = ChunkBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [ActionW-1:0] action_i,
  input  logic [IndexW-1:0]  reg_index_i,
  input  logic [DataW-1:0]   write_data_i,
  output mzf_entry_t         entry_o
);

  logic             busy_q, busy_d;
  logic [DataW-1:0] addr_q, addr_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] first_q, first_d;
  logic [DataW-1:0] last_q, last_d;

  logic             in_range;
  logic             fits;
  logic [DataW-1:0] chunk;
  logic [DataW-1:0] len;

  // Size the next chunk
  assign in_range = {{(IdxCmpW-IndexW){1'b0}}, reg_index_i} < IdxCmpW'(RegWords);
  assign chunk    = DataW'(ChunkBytes);
  assign fits     = (rem_q != '0) && (rem_q <= chunk);
  assign len      = fits ? rem_q : chunk;

  // Classify the request and advance the fill state
  always_comb begin
    busy_d  = busy_q;
    addr_d  = addr_q;
    rem_d   = rem_q;
    first_d = first_q;
    last_d  = last_q;

    entry_o              = '0;
    entry_o.index        = reg_index_i;
    entry_o.wdata        = write_data_i;

    unique case (action_i)
      ActRead: begin
        entry_o.mem_re = in_range;
      end
      ActWrite: begin
        entry_o.mem_we = in_range;
        if (reg_index_i == WordFirst) begin
          first_d = write_data_i;
        end
        if (reg_index_i == WordLast) begin
          last_d = write_data_i;
        end
        if (reg_index_i == WordOperation) begin
          if ((write_data_i != OpcodeZeroFill) || busy_q || (last_q < first_q)) begin
            entry_o.op_error = 1'b1;
          end else begin
            busy_d = 1'b1;
            addr_d = first_q;
            rem_d  = last_q - first_q + 64'd1;
          end
        end
      end
      ActTick: begin
        if (busy_q) begin
          entry_o.fill_valid   = 1'b1;
          entry_o.fill_address = addr_q;
          entry_o.fill_length  = len[LenW-1:0];
          entry_o.fill_last    = fits;
          addr_d = addr_q + len;
          rem_d  = rem_q - len;
          if (fits) begin
            busy_d = 1'b0;
            rem_d  = '0;
          end
        end
      end
      default: begin
      end
    endcase

    entry_o.busy = busy_d;
  end

  // Update fill state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      addr_q  <= '0;
      rem_q   <= '0;
      first_q <= '0;
      last_q  <= '0;
    end else if (push_i) begin
      busy_q  <= busy_d;
      addr_q  <= addr_d;
      rem_q   <= rem_d;
      first_q <= first_d;
      last_q  <= last_d;
    end
  end

endmodule

@@ hw/rtl/mzf_queue.sv @@
module mzf_queue import mzf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  mzf_entry_t entry_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       avail_o,
  output mzf_entry_t entry_o
);

  mzf_entry_t       slots_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign avail_o = (cnt_q != '0);
  assign entry_o = slots_q[rd_ptr_q];

  // Store pushed requests
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/mzf_back.sv @@
module mzf_back import mzf_pkg::*; #(
  parameter int unsigned RegWords = RegWordsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             avail_i,
  input  mzf_entry_t       entry_i,
  output logic             pop_o,
  output logic             clearing_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] read_data_o,
  output logic             fill_valid_o,
  output logic [DataW-1:0] fill_address_o,
  output logic [LenW-1:0]  fill_length_o,
  output logic             fill_last_o,
  output logic             op_error_o,
  output logic             busy_res_o
);

  localparam int unsigned AW = $clog2(RegWords);

  logic [DataW-1:0] mem [RegWords];
  logic             clr_q;
  logic [AW-1:0]    clr_cnt_q;
  logic [AW-1:0]    addr;
  logic             out_valid_q;

  logic [DataW-1:0] rd_q;
  logic             fill_valid_q;
  logic [DataW-1:0] fill_address_q;
  logic [LenW-1:0]  fill_length_q;
  logic             fill_last_q;
  logic             op_error_q;
  logic             busy_q;

  assign addr       = AW'(entry_i.index);
  assign pop_o      = avail_i && !clr_q && (!out_valid_q || !out_stall_i);
  assign clearing_o = clr_q;

  // Clear the register file after reset, one word a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(RegWords - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Register file access and output payload
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (pop_o && entry_i.mem_we) begin
      mem[addr] <= entry_i.wdata;
    end
    if (pop_o) begin
      if (entry_i.mem_re) begin
        rd_q <= mem[addr];
      end else begin
        rd_q <= '0;
      end
      fill_valid_q   <= entry_i.fill_valid;
      fill_address_q <= entry_i.fill_address;
      fill_length_q  <= entry_i.fill_length;
      fill_last_q    <= entry_i.fill_last;
      op_error_q     <= entry_i.op_error;
      busy_q         <= entry_i.busy;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = rd_q;
  assign fill_valid_o   = fill_valid_q;
  assign fill_address_o = fill_address_q;
  assign fill_length_o  = fill_length_q;
  assign fill_last_o    = fill_last_q;
  assign op_error_o     = op_error_q;
  assign busy_res_o     = busy_q;

endmodule

@@ hw/rtl/memory_zero_fill_engine.sv @@
// Zero-fill engine behind a 64-bit word register file.
// Input channel (in_valid_i / in_stall_o) carries one request: a register
// read, a register write, or a tick that advances a running fill. Writing
// the start code to the operation word launches a fill over the range held
// in the first-address and last-address words.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// request: read data, a zero-write chunk (address, length, last flag), an
// operation error flag and the busy state after the request.
// Throughput: one request per cycle while the output is not stalled. The front
// classifies and updates fill state in the accept cycle; the back does the
// register-file access and loads the output register. An accepted request
// waits in a two-entry queue between the halves until the back pops it.
// Reset: all fill state clears, then the back sweeps the register file to
// zero, one word a cycle; in_stall_o is high meanwhile.
// A stalled output holds its result; the queue keeps taking requests until
// it fills, then in_stall_o rises.
module memory_zero_fill_engine import mzf_pkg::*; #(
  parameter int unsigned RegWords   = RegWordsDef,
  parameter int unsigned ChunkBytes = ChunkBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ActionW-1:0] action_i,
  input  logic [IndexW-1:0]  reg_index_i,
  input  logic [DataW-1:0]   write_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DataW-1:0]   read_data_o,
  output logic               fill_valid_o,
  output logic [DataW-1:0]   fill_address_o,
  output logic [LenW-1:0]    fill_length_o,
  output logic               fill_last_o,
  output logic               op_error_o,
  output logic               busy_res_o
);

  mzf_entry_t front_entry;
  mzf_entry_t head_entry;
  logic       push;
  logic       pop;
  logic       full;
  logic       avail;
  logic       clearing;

  // Accept when the queue has room and the clearing sweep is done
  assign in_stall_o = full || clearing;
  assign push       = in_valid_i && !in_stall_o;

  mzf_front #(
    .RegWords   (RegWords),
    .ChunkBytes (ChunkBytes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .action_i     (action_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .entry_o      (front_entry)
  );

  mzf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .full_o  (full),
    .avail_o (avail),
    .entry_o (head_entry)
  );

  mzf_back #(
    .RegWords (RegWords)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .avail_i        (avail),
    .entry_i        (head_entry),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_data_o    (read_data_o),
    .fill_valid_o   (fill_valid_o),
    .fill_address_o (fill_address_o),
    .fill_length_o  (fill_length_o),
    .fill_last_o    (fill_last_o),
    .op_error_o     (op_error_o),
    .busy_res_o     (busy_res_o)
  );

endmodule
